>>> rtl/ild_pkg.sv
// Shared types, constants and opcode tables for the x86 instruction length decoder.
package ild_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_ESCAPE = 3'd1,
    PH_MODRM  = 3'd2,
    PH_SIB    = 3'd3,
    PH_TAIL   = 3'd4
  } phase_e;

  // CPU mode register codes
  localparam logic [1:0] MODE_LEGACY = 2'd0;
  localparam logic [1:0] MODE_COMPAT = 2'd1;
  localparam logic [1:0] MODE_LONG   = 2'd2;

  // Opcode and prefix bytes
  localparam logic [7:0] OPC_ESCAPE   = 8'h0F;
  localparam logic [7:0] PFX_OPSIZE   = 8'h66;
  localparam logic [7:0] PFX_ADDRSIZE = 8'h67;
  localparam logic [7:0] PFX_LOCK     = 8'hF0;
  localparam logic [7:0] PFX_REPNE    = 8'hF2;
  localparam logic [7:0] PFX_REP      = 8'hF3;
  localparam logic [7:0] PFX_SEG_ES   = 8'h26;
  localparam logic [7:0] PFX_SEG_CS   = 8'h2E;
  localparam logic [7:0] PFX_SEG_SS   = 8'h36;
  localparam logic [7:0] PFX_SEG_DS   = 8'h3E;
  localparam logic [7:0] PFX_SEG_FS   = 8'h64;
  localparam logic [7:0] PFX_SEG_GS   = 8'h65;
  localparam logic [3:0] REX_HIGH     = 4'h4;
  localparam logic [7:0] OPC_GRP3_B   = 8'hF6;
  localparam logic [7:0] OPC_GRP3_V   = 8'hF7;
  localparam logic [7:0] OPC_CALLF    = 8'h9A;
  localparam logic [7:0] OPC_JMPF     = 8'hEA;
  localparam logic [5:0] OPC_MOFFS_HI = 6'b101000;

  // ModR/M fields
  localparam logic [1:0] MOD_MEM0 = 2'b00;
  localparam logic [1:0] MOD_MEM8 = 2'b01;
  localparam logic [1:0] MOD_REG  = 2'b11;
  localparam logic [2:0] RM_SIB   = 3'd4;
  localparam logic [2:0] RM_DISP  = 3'd5;

  // Immediate classes
  localparam logic [2:0] IMM_NONE = 3'd0;
  localparam logic [2:0] IMM_B    = 3'd1;
  localparam logic [2:0] IMM_W    = 3'd2;
  localparam logic [2:0] IMM_V    = 3'd3;
  localparam logic [2:0] IMM_WB   = 3'd4;

  // One result as it leaves the parser
  typedef struct packed {
    logic [4:0] instr_length;
    logic       two_byte_opcode;
    logic [7:0] opcode_byte;
    logic       length_overflow;
  } ild_result_t;

  // Two nibbles per byte: bit 0 = ModR/M follows, bits 3:1 = immediate class.
  // Lower half is the one-byte map, upper half the 0F map.
  localparam logic [7:0] OP_ROM [256] = '{
    8'h11, 8'h11, 8'h26, 8'h00, 8'h11, 8'h11, 8'h26, 8'h00,
    8'h11, 8'h11, 8'h26, 8'h00, 8'h11, 8'h11, 8'h26, 8'h00,
    8'h11, 8'h11, 8'h26, 8'h00, 8'h11, 8'h11, 8'h26, 8'h00,
    8'h11, 8'h11, 8'h26, 8'h00, 8'h11, 8'h11, 8'h26, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h11, 8'h00, 8'h00, 8'h67, 8'h23, 8'h00, 8'h00,
    8'h22, 8'h22, 8'h22, 8'h22, 8'h22, 8'h22, 8'h22, 8'h22,
    8'h37, 8'h33, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h26, 8'h00, 8'h00, 8'h00,
    8'h22, 8'h22, 8'h22, 8'h22, 8'h66, 8'h66, 8'h66, 8'h66,
    8'h33, 8'h40, 8'h11, 8'h37, 8'h80, 8'h40, 8'h02, 8'h00,
    8'h11, 8'h11, 8'h22, 8'h00, 8'h11, 8'h11, 8'h11, 8'h11,
    8'h22, 8'h22, 8'h22, 8'h22, 8'h66, 8'h02, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h11, 8'h00, 8'h00, 8'h00, 8'h11,
    8'h11, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
    8'h11, 8'h11, 8'h11, 8'h11, 8'h10, 8'h00, 8'h00, 8'h01,
    8'h11, 8'h11, 8'h10, 8'h10, 8'h11, 8'h11, 8'h11, 8'h11,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h10, 8'h00, 8'h00,
    8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11,
    8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11,
    8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11,
    8'h33, 8'h11, 8'h11, 8'h10, 8'h00, 8'h00, 8'h11, 8'h11,
    8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66,
    8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11,
    8'h00, 8'h01, 8'h31, 8'h00, 8'h00, 8'h01, 8'h31, 8'h11,
    8'h11, 8'h11, 8'h11, 8'h11, 8'h00, 8'h11, 8'h11, 8'h11,
    8'h11, 8'h31, 8'h33, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11,
    8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11,
    8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h10
  };

  // Look up the opcode nibble; odd opcodes use the low half of the byte
  function automatic logic [3:0] rom_nibble(input logic [7:0] opc, input logic esc);
    logic [7:0] v;
    v = OP_ROM[{esc, opc[7:1]}];
    return opc[0] ? v[3:0] : v[7:4];
  endfunction

  // Legacy prefixes other than operand size
  function automatic logic is_legacy_prefix(input logic [7:0] b);
    logic r;
    unique case (b) inside
      PFX_LOCK, PFX_REPNE, PFX_REP, PFX_SEG_ES, PFX_SEG_CS, PFX_SEG_SS,
      PFX_SEG_DS, PFX_SEG_FS, PFX_SEG_GS, PFX_ADDRSIZE: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Bytes after ModR/M, SIB and displacement: immediate plus special opcodes
  function automatic logic [3:0] tail_bytes(input logic [7:0] opc, input logic esc,
                                            input logic [7:0] modrm, input logic osp);
    logic [3:0] nib;
    logic [2:0] cls;
    logic [3:0] extra;
    nib   = rom_nibble(opc, esc);
    cls   = nib[3:1];
    extra = 4'd0;
    if (!esc) begin
      // test forms of group 3 carry an immediate
      if (modrm[5:4] == 2'b00) begin
        if (opc == OPC_GRP3_B) cls = cls | IMM_B;
        else if (opc == OPC_GRP3_V) cls = cls | IMM_V;
      end
      if (opc == OPC_CALLF || opc == OPC_JMPF) extra = 4'd6;
      if (opc[7:2] == OPC_MOFFS_HI) extra = 4'd4;
    end
    case (cls)
      IMM_B:   extra = extra + 4'd1;
      IMM_W:   extra = extra + 4'd2;
      IMM_V:   extra = extra + (osp ? 4'd2 : 4'd4);
      IMM_WB:  extra = extra + 4'd3;
      default: extra = extra;
    endcase
    return extra;
  endfunction

endpackage

>>> rtl/x86_instruction_length_decoder.sv
// Top level: input byte register, parser and result register of the length decoder.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | request   | in_valid_i/in_stall_o | code_byte_i
//   out     | result    | out_valid_o/out_stall_i | instr_length_o, two_byte_opcode_o,
//           |           |                       | opcode_byte_o, length_overflow_o
//   cfg     | write     | cfg_we_i              | cfg_wdata_i (cpu mode)
//
// One byte is taken per cycle while the input is not stalled; each byte is held in the
// input register and parsed on its way to the result register, so the last byte of an
// instruction is registered first and then its result, before the result is valid.
// Reset clears the parser to the start of an instruction and sets the cpu mode to
// 32-bit compatibility. A stalled result holds the result register and, once the
// input register is full, stalls the input channel.
module x86_instruction_length_decoder #(
  parameter int MAX_LENGTH = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] code_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] instr_length_o,
  output logic       two_byte_opcode_o,
  output logic [7:0] opcode_byte_o,
  output logic       length_overflow_o
);

  logic [1:0]           cpu_mode_q;
  logic                 byte_vld_q, byte_vld_d;
  logic [7:0]           byte_q;
  logic                 out_valid_q, out_valid_d;
  ild_pkg::ild_result_t res_q;
  ild_pkg::ild_result_t res;
  logic                 adv;
  logic                 fire;
  logic                 emit;
  logic                 in_acc;

  // Advance when the result register is free or being drained
  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = byte_vld_q && !adv;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign fire        = byte_vld_q && adv;
  assign byte_vld_d  = (byte_vld_q && !adv) || in_acc;
  assign out_valid_d = adv ? emit : out_valid_q;

  ild_parse #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .code_byte_i(byte_q),
    .cpu_mode_i (cpu_mode_q),
    .emit_o     (emit),
    .result_o   (res)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_mode_q  <= ild_pkg::MODE_COMPAT;
      byte_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cpu_mode_q <= cfg_wdata_i;
      byte_vld_q  <= byte_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load the byte on accept, the result on emit
  always_ff @(posedge clk_i) begin
    if (in_acc) byte_q <= code_byte_i;
    if (emit) res_q <= res;
  end

  assign out_valid_o       = out_valid_q;
  assign instr_length_o    = res_q.instr_length;
  assign two_byte_opcode_o = res_q.two_byte_opcode;
  assign opcode_byte_o     = res_q.opcode_byte;
  assign length_overflow_o = res_q.length_overflow;

endmodule

>>> rtl/ild_parse.sv
// Byte-wise parser state machine: tracks prefixes, opcode, ModR/M, SIB and tail bytes.
module ild_parse #(
  parameter int MAX_LENGTH = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           code_byte_i,
  input  logic [1:0]           cpu_mode_i,
  output logic                 emit_o,
  output ild_pkg::ild_result_t result_o
);

  localparam int CntW = ($clog2(MAX_LENGTH + 1) > 5) ? $clog2(MAX_LENGTH + 1) : 5;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_LENGTH);

  ild_pkg::phase_e phase_q, phase_d;
  logic            osp_q, osp_d;
  logic            esc_q, esc_d;
  logic [7:0]      opc_q, opc_d;
  logic [7:0]      modrm_q, modrm_d;
  logic [3:0]      rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [7:0]      b;
  logic            legacy;
  logic            skip_pfx;
  logic [3:0]      op_nib;
  logic [3:0]      op_tail;
  logic            op_done;
  logic [3:0]      mr_tail;
  logic            mr_to_sib;
  logic [2:0]      mr_disp;
  logic [4:0]      mr_n;
  logic [3:0]      sib_tail;
  logic [2:0]      sib_disp;
  logic [4:0]      sib_n;
  logic [3:0]      rem_dec;
  logic [CntW-1:0] cnt_inc;
  logic            takes_op;
  logic            done;

  // Decode helpers shared by the phases
  assign b        = code_byte_i;
  assign legacy   = (cpu_mode_i == ild_pkg::MODE_LEGACY);
  assign skip_pfx = ((cpu_mode_i == ild_pkg::MODE_LONG) && (b[7:4] == ild_pkg::REX_HIGH)) ||
                    ild_pkg::is_legacy_prefix(b);
  assign op_nib   = ild_pkg::rom_nibble(b, esc_q);
  assign op_tail  = ild_pkg::tail_bytes(b, esc_q, 8'h00, osp_q);
  assign op_done  = !op_nib[0] && (op_tail == 4'd0);
  assign mr_tail  = ild_pkg::tail_bytes(opc_q, esc_q, b, osp_q);
  assign mr_to_sib = (b[7:6] != ild_pkg::MOD_REG) && !legacy && (b[2:0] == ild_pkg::RM_SIB);
  assign sib_tail = ild_pkg::tail_bytes(opc_q, esc_q, modrm_q, osp_q);
  assign mr_n     = 5'(mr_disp) + 5'(mr_tail);
  assign sib_n    = 5'(sib_disp) + 5'(sib_tail);
  assign rem_dec  = (rem_q == 4'd0) ? 4'd0 : rem_q - 4'd1;
  assign cnt_inc  = (cnt_q < CntMax) ? cnt_q + CntW'(1) : cnt_q;
  assign takes_op = (phase_q == ild_pkg::PH_ESCAPE) ||
                    ((phase_q != ild_pkg::PH_MODRM) && (phase_q != ild_pkg::PH_SIB) &&
                     (phase_q != ild_pkg::PH_TAIL));

  // Count displacement bytes from mod, rm and the addressing mode
  always_comb begin
    case (b[7:6])
      ild_pkg::MOD_MEM0: mr_disp = (b[2:0] == ild_pkg::RM_DISP) ? (legacy ? 3'd2 : 3'd4) : 3'd0;
      ild_pkg::MOD_MEM8: mr_disp = 3'd1;
      ild_pkg::MOD_REG:  mr_disp = 3'd0;
      default:           mr_disp = legacy ? 3'd2 : 3'd4;
    endcase
    case (modrm_q[7:6])
      ild_pkg::MOD_MEM0: sib_disp = (b[2:0] == ild_pkg::RM_DISP) ? 3'd4 : 3'd0;
      ild_pkg::MOD_MEM8: sib_disp = 3'd1;
      default:           sib_disp = 3'd4;
    endcase
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    osp_d   = osp_q;
    esc_d   = esc_q;
    opc_d   = opc_q;
    modrm_d = modrm_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    if (fire_i) begin
      cnt_d = cnt_inc;
      unique case (phase_q)
        ild_pkg::PH_ESCAPE: begin
          opc_d   = b;
          modrm_d = 8'h00;
          rem_d   = op_tail;
          phase_d = op_nib[0] ? ild_pkg::PH_MODRM : ild_pkg::PH_TAIL;
        end
        ild_pkg::PH_MODRM: begin
          modrm_d = b;
          rem_d   = mr_n[3:0];
          phase_d = mr_to_sib ? ild_pkg::PH_SIB : ild_pkg::PH_TAIL;
        end
        ild_pkg::PH_SIB: begin
          rem_d   = sib_n[3:0];
          phase_d = ild_pkg::PH_TAIL;
        end
        ild_pkg::PH_TAIL: begin
          rem_d = rem_dec;
        end
        default: begin
          phase_d = ild_pkg::PH_PREFIX;
          if (skip_pfx) begin
            phase_d = ild_pkg::PH_PREFIX;
          end else if (b == ild_pkg::PFX_OPSIZE) begin
            osp_d = 1'b1;
          end else if (b == ild_pkg::OPC_ESCAPE) begin
            esc_d   = 1'b1;
            phase_d = ild_pkg::PH_ESCAPE;
          end else begin
            opc_d   = b;
            modrm_d = 8'h00;
            rem_d   = op_tail;
            phase_d = op_nib[0] ? ild_pkg::PH_MODRM : ild_pkg::PH_TAIL;
          end
        end
      endcase
      // last byte: back to the start of the next instruction
      if (done) begin
        phase_d = ild_pkg::PH_PREFIX;
        osp_d   = 1'b0;
        esc_d   = 1'b0;
        rem_d   = 4'd0;
        cnt_d   = '0;
      end
    end
  end

  // Outputs: last-byte detection and the result fields
  always_comb begin
    unique case (phase_q)
      ild_pkg::PH_ESCAPE: done = op_done;
      ild_pkg::PH_MODRM:  done = !mr_to_sib && (mr_n == 5'd0);
      ild_pkg::PH_SIB:    done = (sib_n == 5'd0);
      ild_pkg::PH_TAIL:   done = (rem_dec == 4'd0);
      default:            done = !skip_pfx && (b != ild_pkg::PFX_OPSIZE) &&
                                 (b != ild_pkg::OPC_ESCAPE) && op_done;
    endcase
    emit_o                   = fire_i && done;
    result_o.instr_length    = cnt_inc[4:0];
    result_o.two_byte_opcode = esc_q;
    result_o.opcode_byte     = takes_op ? b : opc_q;
    result_o.length_overflow = (cnt_inc >= CntMax);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ild_pkg::PH_PREFIX;
      osp_q   <= 1'b0;
      esc_q   <= 1'b0;
      opc_q   <= 8'h00;
      modrm_q <= 8'h00;
      rem_q   <= 4'd0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      osp_q   <= osp_d;
      esc_q   <= esc_d;
      opc_q   <= opc_d;
      modrm_q <= modrm_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/ild_checker.sv
// Port-level checks for the length decoder, bound to the top level.
module ild_checker #(
  parameter int MAX_LENGTH = 31
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_i,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [4:0] instr_length_i,
  input logic       two_byte_opcode_i,
  input logic [7:0] opcode_byte_i,
  input logic       length_overflow_i
);

  localparam bit         SmallMax = (MAX_LENGTH < 32);
  localparam logic [4:0] MaxLow   = 5'(MAX_LENGTH % 32);

  // Hold a stalled request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_i |=> in_valid_i)
    else $error("request dropped while stalled");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(instr_length_i) && $stable(two_byte_opcode_i) &&
                                   $stable(opcode_byte_i) && $stable(length_overflow_i))
    else $error("stalled result changed");

  // Input stalls only under a stalled pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("input stalled without output backpressure");

  // Overflow flag marks a length at the limit
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && SmallMax |-> length_overflow_i == (instr_length_i == MaxLow))
    else $error("overflow flag disagrees with length");

endmodule

bind x86_instruction_length_decoder ild_checker #(
  .MAX_LENGTH(MAX_LENGTH)
) u_ild_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_i       (in_stall_o),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .instr_length_i   (instr_length_o),
  .two_byte_opcode_i(two_byte_opcode_o),
  .opcode_byte_i    (opcode_byte_o),
  .length_overflow_i(length_overflow_o)
);
